/* rtl/coulomb_glass_metropolis_step_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the exchange engine
// Shared forms for concurrent checks, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef COULOMB_GLASS_METROPOLIS_STEP_ASSERT_SVH
`define COULOMB_GLASS_METROPOLIS_STEP_ASSERT_SVH

// Condition must hold at every clock edge out of reset
`define CGM_ASSERT(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CGM_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/cgm_pkg.sv */
// ----------------------------------------------------------------------------
// cgm_pkg
// Types, constants and elaboration-time table functions of the exchange engine.
// ----------------------------------------------------------------------------
package cgm_pkg;

  localparam int CGM_SIDE_DEF    = 16;
  localparam int CGM_EXP_DEF     = 256;
  localparam int EN_W            = 32;
  localparam int BETA_W          = 24;
  localparam int DRAW_W          = 16;
  localparam int IN_TDATA_W      = 72;
  localparam int OUT_TDATA_W     = 136;
  localparam int CFG_IDX_W       = 2;
  localparam int X16_W           = 39;
  localparam logic [23:0] BETA_RST = 24'd65536;
  localparam logic [127:0] EXP_M1_Q32 = 128'd1580030169;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PROPOSE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA  = 2'd0,
    CFG_START = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_WR,
    OP_RESTART,
    OP_RD_E,
    OP_RD_H,
    OP_DIFF,
    OP_MUL,
    OP_INDEX,
    OP_LOOKUP,
    OP_DECIDE,
    OP_SWEEP,
    OP_READ_OUT,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic acc;
    logic sweep_done;
    logic out_free;
  } cgm_status_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clip_t;

  // Saturate a widened sum to the signed 32-bit range
  function automatic clip_t clip34(input logic signed [33:0] v);
    clip_t r;
    if (v > 34'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // Integer square root, bit by bit (table building only)
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = v;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > x) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // exp(-x) in Q1.16 for x in Q32 (table building only)
  function automatic logic [16:0] exp_entry(input logic [63:0] xv);
    logic [127:0]        n;
    logic [127:0]        f;
    logic [127:0]        term;
    logic signed [127:0] sum;
    logic [127:0]        v;
    n    = 128'(xv >> 32);
    f    = 128'(xv[31:0]);
    term = 128'd1 << 32;
    sum  = $signed(term);
    for (int k = 1; k <= 24; k++) begin
      term = ((term * f) >> 32) / 128'(k);
      if ((k % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    v = (sum < 0) ? '0 : 128'(sum);
    for (int i = 0; i < 16; i++) begin
      if (128'(i) < n) v = (v * EXP_M1_Q32 + (128'd1 << 31)) >> 32;
    end
    return 17'((v + (128'd1 << 15)) >> 16);
  endfunction

endpackage

/* rtl/cgm_ram.sv */
// ----------------------------------------------------------------------------
// cgm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cgm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cgm_ctrl.sv */
// ----------------------------------------------------------------------------
// cgm_ctrl
// Command sequencer: walks each item through its datapath steps.
// ----------------------------------------------------------------------------
module cgm_ctrl
  import cgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  cmd_t        in_cmd,
  input  cgm_status_t status,
  output logic        in_tready,
  output dp_op_t      op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RESTART,
    S_RD_E,
    S_RD_H,
    S_DIFF,
    S_MUL,
    S_INDEX,
    S_LOOKUP,
    S_DECIDE,
    S_CHECK,
    S_SWEEP,
    S_RD_OUT,
    S_WAIT
  } state_t;

  state_t state_r;

  assign in_tready = (state_r == S_IDLE);

  // Decode the datapath step for each state
  always_comb begin
    unique case (state_r)
      S_IDLE:    op = in_tvalid ? OP_CAPTURE : OP_NONE;
      S_LOAD:    op = OP_LOAD_WR;
      S_RESTART: op = OP_RESTART;
      S_RD_E:    op = OP_RD_E;
      S_RD_H:    op = OP_RD_H;
      S_DIFF:    op = OP_DIFF;
      S_MUL:     op = OP_MUL;
      S_INDEX:   op = OP_INDEX;
      S_LOOKUP:  op = OP_LOOKUP;
      S_DECIDE:  op = OP_DECIDE;
      S_CHECK:   op = OP_NONE;
      S_SWEEP:   op = OP_SWEEP;
      S_RD_OUT:  op = OP_READ_OUT;
      S_WAIT:    op = status.out_free ? OP_LOAD_OUT : OP_READ_OUT;
      default:   op = OP_NONE;
    endcase
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            unique case (in_cmd)
              CMD_LOAD:    state_r <= S_LOAD;
              CMD_PROPOSE: state_r <= S_RD_E;
              CMD_READ:    state_r <= S_RD_OUT;
              CMD_RESTART: state_r <= S_RESTART;
              default:     state_r <= S_RD_OUT;
            endcase
          end
        end
        S_LOAD:    state_r <= S_RD_OUT;
        S_RESTART: state_r <= S_RD_OUT;
        S_RD_E:    state_r <= S_RD_H;
        S_RD_H:    state_r <= S_DIFF;
        S_DIFF:    state_r <= S_MUL;
        S_MUL:     state_r <= S_INDEX;
        S_INDEX:   state_r <= S_LOOKUP;
        S_LOOKUP:  state_r <= S_DECIDE;
        S_DECIDE:  state_r <= S_CHECK;
        S_CHECK:   state_r <= status.acc ? S_SWEEP : S_RD_OUT;
        S_SWEEP: begin
          if (status.sweep_done) state_r <= S_RD_OUT;
        end
        S_RD_OUT:  state_r <= S_WAIT;
        S_WAIT: begin
          if (status.out_free) state_r <= S_IDLE;
        end
        default:   state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/cgm_datapath.sv */
// ----------------------------------------------------------------------------
// cgm_datapath
// Lattice memories, distance and exp tables, energy arithmetic, result beat.
// ----------------------------------------------------------------------------
`include "coulomb_glass_metropolis_step_assert.svh"

module cgm_datapath
  import cgm_pkg::*;
#(
  parameter int LATTICE_SIDE      = CGM_SIDE_DEF,
  parameter int EXP_TABLE_ENTRIES = CGM_EXP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_op_t                 op,
  output cgm_status_t            status,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SITES = LATTICE_SIDE * LATTICE_SIDE;
  localparam int AW    = $clog2(SITES);
  localparam int CW    = $clog2(LATTICE_SIDE);
  localparam int EW    = $clog2(EXP_TABLE_ENTRIES);
  localparam int PW    = X16_W + EW + 1;

  // Fold an input coordinate into the lattice
  function automatic logic [CW-1:0] wrap_coord(input logic [3:0] v);
    int unsigned t;
    t = 32'(v);
    for (int i = 0; i < 4; i++) begin
      if (t >= LATTICE_SIDE) t = t - LATTICE_SIDE;
    end
    return CW'(t);
  endfunction

  function automatic logic [CW-1:0] adiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(int'(x) * LATTICE_SIDE + int'(y));
  endfunction

  // Constant tables
  logic [15:0] idist_rom [SITES];
  logic [16:0] exp_rom   [EXP_TABLE_ENTRIES];

  for (genvar gx = 0; gx < LATTICE_SIDE; gx++) begin : g_dx
    for (genvar gy = 0; gy < LATTICE_SIDE; gy++) begin : g_dy
      localparam longint K  = (gx > LATTICE_SIDE / 2) ? LATTICE_SIDE - gx : gx;
      localparam longint J  = (gy > LATTICE_SIDE / 2) ? LATTICE_SIDE - gy : gy;
      localparam longint R2 = K * K + J * J;
      localparam logic [63:0] Q = (64'd1 << 32) / ((R2 == 0) ? 64'd1 : 64'(R2));
      localparam logic [15:0] V = (R2 == 0) ? 16'd0 : 16'((isqrt64(Q) + 64'd1) >> 1);
      assign idist_rom[gx * LATTICE_SIDE + gy] = V;
    end
  end

  for (genvar gi = 0; gi < EXP_TABLE_ENTRIES; gi++) begin : g_exp
    localparam logic [63:0] XV = (64'(gi) << 36) / EXP_TABLE_ENTRIES;
    localparam logic [16:0] EV = exp_entry(XV);
    assign exp_rom[gi] = EV;
  end

  // Item and working registers
  logic [CW-1:0]      ex_r, ey_r, hx_r, hy_r, sx_r, sy_r;
  logic [AW-1:0]      e_r, h_r, s_d_r;
  logic [AW:0]        cnt_r;
  logic               rd_v_r;
  logic [DRAW_W-1:0]  draw_r;
  logic               ld_occ_r;
  logic signed [31:0] ld_en_r, ee_r, de_r, run_r, low_r, start_r;
  logic [BETA_W-1:0]  beta_r;
  logic [X16_W-1:0]   x16_r;
  logic [EW-1:0]      idx_r;
  logic               in_rng_r;
  logic [16:0]        expq_r;
  logic [15:0]        rom_a_r, rom_b_r;
  logic               acc_r, sat_r, new_min_r, snap_ok_r, out_valid_r;
  logic [OUT_TDATA_W-1:0] out_r;

  // Memory ports
  logic [AW-1:0]      ram_ra, ram_wa;
  logic               en_we, occ_we, snap_we;
  logic [31:0]        en_wd, en_rd;
  logic               occ_wd, occ_rd, snap_rd;
  logic [AW-1:0]      rom_a_addr, rom_b_addr;

  cgm_ram #(.WIDTH(32), .DEPTH(SITES)) u_energy (
    .clk(clk), .we(en_we), .waddr(ram_wa), .wdata(en_wd), .raddr(ram_ra), .rdata(en_rd)
  );
  cgm_ram #(.WIDTH(1), .DEPTH(SITES)) u_occ (
    .clk(clk), .we(occ_we), .waddr(ram_wa), .wdata(occ_wd), .raddr(ram_ra), .rdata(occ_rd)
  );
  cgm_ram #(.WIDTH(1), .DEPTH(SITES)) u_snap (
    .clk(clk), .we(snap_we), .waddr(ram_wa), .wdata(occ_wd), .raddr(ram_ra), .rdata(snap_rd)
  );

  // Combinational arithmetic
  logic signed [33:0] diff_sum, sweep_sum, run_sum;
  clip_t              diff_c, sweep_c, run_c;
  logic [54:0]        prod;
  logic [PW-1:0]      idx_full, idx_hi;
  logic               accept;
  logic               sweep_rd;

  assign diff_sum  = 34'($signed(en_rd)) - 34'(ee_r) - $signed(34'({rom_a_r, 1'b0}));
  assign sweep_sum = 34'($signed(en_rd)) + $signed(34'({rom_a_r, 1'b0}))
                     - $signed(34'({rom_b_r, 1'b0}));
  assign run_sum   = 34'(run_r) + 34'(de_r);
  assign diff_c    = clip34(diff_sum);
  assign sweep_c   = clip34(sweep_sum);
  assign run_c     = clip34(run_sum);
  assign prod      = 55'(de_r[30:0]) * 55'(beta_r);
  assign idx_full  = PW'(x16_r) * PW'(EXP_TABLE_ENTRIES);
  assign idx_hi    = idx_full >> 20;
  assign accept    = de_r[31] | (in_rng_r & ({1'b0, draw_r} < expq_r));
  assign sweep_rd  = (op == OP_SWEEP) && (cnt_r < (AW + 1)'(SITES));

  // Select read addresses
  always_comb begin
    case (op)
      OP_RD_H:  ram_ra = h_r;
      OP_SWEEP: ram_ra = cnt_r[AW-1:0];
      default:  ram_ra = e_r;
    endcase
    if (op == OP_SWEEP) begin
      rom_a_addr = site_addr(adiff(sx_r, hx_r), adiff(sy_r, hy_r));
    end else begin
      rom_a_addr = site_addr(adiff(ex_r, hx_r), adiff(ey_r, hy_r));
    end
    rom_b_addr = site_addr(adiff(sx_r, ex_r), adiff(sy_r, ey_r));
  end

  // Select write port: load beat or sweep write-back
  always_comb begin
    if (rd_v_r) begin
      ram_wa  = s_d_r;
      en_we   = 1'b1;
      en_wd   = sweep_c.val;
      occ_we  = 1'b1;
      occ_wd  = occ_rd ^ (s_d_r == e_r) ^ (s_d_r == h_r);
      snap_we = new_min_r;
    end else begin
      ram_wa  = e_r;
      en_we   = (op == OP_LOAD_WR);
      en_wd   = ld_en_r;
      occ_we  = (op == OP_LOAD_WR);
      occ_wd  = ld_occ_r;
      snap_we = 1'b0;
    end
  end

  assign status.acc        = acc_r;
  assign status.sweep_done = (cnt_r == (AW + 1)'(SITES)) && !rd_v_r;
  assign status.out_free   = !out_valid_r || out_tready;
  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_r;

  // Control state: config, totals, flags, sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r      <= BETA_RST;
      start_r     <= '0;
      run_r       <= '0;
      low_r       <= '0;
      snap_ok_r   <= 1'b0;
      new_min_r   <= 1'b0;
      acc_r       <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BETA:  beta_r  <= cfg_data[BETA_W-1:0];
          CFG_START: start_r <= $signed(cfg_data);
          default:   ;
        endcase
      end
      rd_v_r <= sweep_rd;
      if (sweep_rd) cnt_r <= cnt_r + 1'b1;
      if (rd_v_r && sweep_c.sat) sat_r <= 1'b1;
      if (op == OP_LOAD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_CAPTURE: begin
          acc_r     <= 1'b0;
          sat_r     <= 1'b0;
          new_min_r <= 1'b0;
        end
        OP_RESTART: begin
          run_r     <= start_r;
          low_r     <= '0;
          snap_ok_r <= 1'b0;
        end
        OP_DIFF: begin
          if (diff_c.sat) sat_r <= 1'b1;
        end
        OP_DECIDE: begin
          acc_r <= accept;
          cnt_r <= '0;
          if (accept) begin
            run_r <= run_c.val;
            if (run_c.sat) sat_r <= 1'b1;
            if (run_c.val < low_r) begin
              low_r     <= run_c.val;
              new_min_r <= 1'b1;
              snap_ok_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rom_a_r <= idist_rom[rom_a_addr];
    rom_b_r <= idist_rom[rom_b_addr];
    s_d_r   <= cnt_r[AW-1:0];
    if (sweep_rd) begin
      if (sy_r == CW'(LATTICE_SIDE - 1)) begin
        sy_r <= '0;
        sx_r <= sx_r + 1'b1;
      end else begin
        sy_r <= sy_r + 1'b1;
      end
    end
    case (op)
      OP_CAPTURE: begin
        ex_r     <= wrap_coord(in_tdata[3:0]);
        ey_r     <= wrap_coord(in_tdata[7:4]);
        hx_r     <= wrap_coord(in_tdata[11:8]);
        hy_r     <= wrap_coord(in_tdata[15:12]);
        e_r      <= site_addr(wrap_coord(in_tdata[3:0]), wrap_coord(in_tdata[7:4]));
        h_r      <= site_addr(wrap_coord(in_tdata[11:8]), wrap_coord(in_tdata[15:12]));
        draw_r   <= in_tdata[31:16];
        ld_occ_r <= in_tdata[32];
        ld_en_r  <= $signed(in_tdata[64:33]);
        de_r     <= '0;
      end
      OP_RD_H:   ee_r <= $signed(en_rd);
      OP_DIFF:   de_r <= diff_c.val;
      OP_MUL:    x16_r <= prod[54:16];
      OP_INDEX: begin
        in_rng_r <= idx_hi < PW'(EXP_TABLE_ENTRIES);
        idx_r    <= idx_hi[EW-1:0];
      end
      OP_LOOKUP: expq_r <= exp_rom[idx_r];
      OP_DECIDE: begin
        sx_r <= '0;
        sy_r <= '0;
      end
      OP_LOAD_OUT: begin
        out_r <= {4'b0, sat_r, en_rd, snap_rd & snap_ok_r, occ_rd,
                  low_r, run_r, de_r, acc_r};
      end
      default: ;
    endcase
  end

  `CGM_ASSERT(a_low_nonpos, clk, rst_n, low_r[31] || (low_r == '0), "minimum energy above zero")
  `CGM_IMPLY(a_min_needs_acc, clk, rst_n, new_min_r, acc_r, "new minimum without acceptance")
  `CGM_IMPLY(a_wb_in_sweep, clk, rst_n, rd_v_r, $past(op) == OP_SWEEP, "write-back outside sweep")

endmodule

/* rtl/coulomb_glass_metropolis_step.sv */
// ----------------------------------------------------------------------------
// coulomb_glass_metropolis_step
// Metropolis electron-hole exchange engine on a periodic Coulomb-glass lattice.
// ----------------------------------------------------------------------------
// Load writes the site, restart resets the totals; each then reads the site
// into the result beat, as read does. An accepted exchange adds a pass over
// the site-energy memory, one site per cycle, that a rejected one skips.
// One item at a time; a finished result waits in an output register while the
// next item is taken. Synchronous active-low reset clears totals and flags and
// resets config; the lattice memories are not cleared, the snapshot reads zero.
module coulomb_glass_metropolis_step
  import cgm_pkg::*;
#(
  parameter int LATTICE_SIDE      = CGM_SIDE_DEF,
  parameter int EXP_TABLE_ENTRIES = CGM_EXP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [3:0] electron_x, [7:4] electron_y, [11:8] hole_x, [15:12] hole_y,
  // [31:16] uniform_draw, [32] load_occupied, [64:33] load_site_energy
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] accepted, [32:1] energy_change, [64:33] total_energy,
  // [96:65] minimum_energy, [97] site_occupied, [98] site_occupied_at_min,
  // [130:99] site_energy_out, [131] saturated
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  dp_op_t      op;
  cgm_status_t status;

  assign cfg_ready = 1'b1;

  cgm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_cmd   (cmd_t'(in_tuser)),
    .status   (status),
    .in_tready(in_tready),
    .op       (op)
  );

  cgm_datapath #(
    .LATTICE_SIDE     (LATTICE_SIDE),
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .status    (status),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata)
  );

endmodule

/* test/cgm_exchange_checker.sv */
// ----------------------------------------------------------------------------
// cgm_exchange_checker
// Watches the command, result and register channels of the exchange engine,
// keeps its own copy of the lattice, predicts every result beat and compares.
// ----------------------------------------------------------------------------
module cgm_exchange_checker
  import cgm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     n_results,
  output int                     n_accepted,
  output int                     n_saturated
);

  typedef struct {
    bit                 acc;
    logic signed [31:0] de;
    logic signed [31:0] total;
    logic signed [31:0] lowest;
    bit                 occ;
    bit                 occ_min;
    logic signed [31:0] site_en;
    bit                 sat;
  } step_result_t;

  step_result_t       result_q[$];
  bit                 occ_map[256];
  bit                 snap_map[256];
  logic signed [31:0] site_en[256];
  logic [15:0]        inv_dist[256];
  logic [16:0]        exp_neg[256];
  logic signed [31:0] run_en;
  logic signed [31:0] low_en;
  logic [23:0]        beta;
  logic signed [31:0] start_en;

  assign pending = result_q.size();

  // floor square root by setting bits from the top
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // periodic inverse distance in Q15.16
  function automatic longint coulomb(input int a, input int b);
    int dx;
    int dy;
    dx = (a / 16) - (b / 16);
    dy = (a % 16) - (b % 16);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(inv_dist[dx * 16 + dy]) * 2;
  endfunction

  // build distance and exp(-x) tables
  initial begin
    longint unsigned     r2;
    int                  k;
    int                  j;
    logic [127:0]        x;
    logic [127:0]        n;
    logic [127:0]        f;
    logic [127:0]        term;
    logic signed [127:0] sum;
    logic [127:0]        v;
    for (int dx = 0; dx < 16; dx++) begin
      for (int dy = 0; dy < 16; dy++) begin
        k = (dx > 8) ? 16 - dx : dx;
        j = (dy > 8) ? 16 - dy : dy;
        r2 = k * k + j * j;
        if (r2 == 0) inv_dist[dx * 16 + dy] = '0;
        else inv_dist[dx * 16 + dy] = 16'((root_floor((64'd1 << 32) / r2) + 1) >> 1);
      end
    end
    for (int i = 0; i < 256; i++) begin
      x    = 128'(i) << 28;
      n    = x >> 32;
      f    = {96'd0, x[31:0]};
      term = 128'd1 << 32;
      sum  = $signed(term);
      for (int t = 1; t <= 24; t++) begin
        term = ((term * f) >> 32) / 128'(t);
        if (t % 2 == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      v = (sum < 0) ? '0 : 128'(sum);
      while (n > 0) begin
        v = (v * 128'd1580030169 + (128'd1 << 31)) >> 32;
        n = n - 1;
      end
      exp_neg[i] = 17'((v + (128'd1 << 15)) >> 16);
    end
  end

  // predict one result per command beat
  always @(posedge clk) begin
    step_result_t       r;
    cmd_t               cmd;
    int                 e;
    int                 h;
    longint             d;
    longint             x16;
    longint             idx;
    longint             sv;
    if (!rst_n) begin
      run_en   = '0;
      low_en   = '0;
      beta     <= BETA_RST;
      start_en <= '0;
      for (int s = 0; s < 256; s++) snap_map[s] = 1'b0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BETA:  beta <= cfg_data[23:0];
          CFG_START: start_en <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        cmd = cmd_t'(in_tuser);
        e   = {in_tdata[3:0], in_tdata[7:4]};
        h   = {in_tdata[11:8], in_tdata[15:12]};
        r   = '{default: 0};
        case (cmd)
          CMD_LOAD: begin
            occ_map[e] = in_tdata[32];
            site_en[e] = in_tdata[64:33];
          end
          CMD_RESTART: begin
            run_en = start_en;
            low_en = '0;
            for (int s = 0; s < 256; s++) snap_map[s] = 1'b0;
          end
          CMD_PROPOSE: begin
            d = longint'(site_en[h]) - longint'(site_en[e]);
            if (e != h) d = d - coulomb(e, h);
            r.de = sat32(d, r.sat);
            if (r.de < 0) begin
              r.acc = 1'b1;
            end else begin
              x16 = (longint'(r.de) * longint'(beta)) >>> 16;
              idx = x16 >>> 12;
              r.acc = (idx < 256) && (longint'(in_tdata[31:16]) < longint'(exp_neg[idx]));
            end
            if (r.acc) begin
              occ_map[e] = ~occ_map[e];
              occ_map[h] = ~occ_map[h];
              for (int s = 0; s < 256; s++) begin
                sv = site_en[s];
                if (s == e || s == h) begin
                  if (s == e) sv = sat32(sv + coulomb(s, h), r.sat);
                  if (s == h) sv = sat32(sv - coulomb(s, e), r.sat);
                end else begin
                  sv = sat32(sv + coulomb(s, h) - coulomb(s, e), r.sat);
                end
                site_en[s] = sv[31:0];
              end
              run_en = sat32(longint'(run_en) + longint'(r.de), r.sat);
              if (run_en < low_en) begin
                low_en = run_en;
                for (int s = 0; s < 256; s++) snap_map[s] = occ_map[s];
              end
            end
          end
          default: ;
        endcase
        r.total   = run_en;
        r.lowest  = low_en;
        r.occ     = occ_map[e];
        r.occ_min = snap_map[e];
        r.site_en = site_en[e];
        result_q.push_back(r);
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    step_result_t r;
    if (!rst_n) begin
      errors      <= 0;
      n_results   <= 0;
      n_accepted  <= 0;
      n_saturated <= 0;
    end else if (out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %h", $time, out_tdata);
        errors <= errors + 1;
      end else begin
        r = result_q.pop_front();
        n_results   <= n_results + 1;
        n_accepted  <= n_accepted + int'(r.acc);
        n_saturated <= n_saturated + int'(r.sat);
        if (out_tdata[0] !== r.acc ||
            out_tdata[32:1] !== r.de ||
            out_tdata[64:33] !== r.total ||
            out_tdata[96:65] !== r.lowest ||
            out_tdata[97] !== r.occ ||
            out_tdata[98] !== r.occ_min ||
            out_tdata[130:99] !== r.site_en ||
            out_tdata[131] !== r.sat) begin
          $display({"%0t: mismatch expected acc=%0b dE=%0d total=%0d min=%0d",
                    " occ=%0b occ_min=%0b site=%0d sat=%0b"},
                   $time, r.acc, r.de, r.total, r.lowest, r.occ, r.occ_min, r.site_en,
                   r.sat);
          $display({"%0t:          actual   acc=%0b dE=%0d total=%0d min=%0d",
                    " occ=%0b occ_min=%0b site=%0d sat=%0b"},
                   $time, out_tdata[0], $signed(out_tdata[32:1]), $signed(out_tdata[64:33]),
                   $signed(out_tdata[96:65]), out_tdata[97], out_tdata[98],
                   $signed(out_tdata[130:99]), out_tdata[131]);
          errors <= errors + 1;
        end
      end
    end
  end

endmodule

/* test/coulomb_glass_metropolis_step_tb.sv */
// ----------------------------------------------------------------------------
// coulomb_glass_metropolis_step_tb
// Fills the lattice, runs directed corner cases and random exchange traffic
// under several temperature and start-energy settings, with random stalls outside the steady ones.
// ----------------------------------------------------------------------------
module coulomb_glass_metropolis_step_tb;
  import cgm_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [31:0]            cfg_data;
  int                     errors;
  int                     pending;
  int                     n_results;
  int                     n_accepted;
  int                     n_saturated;
  bit                     steady;
  int                     hold_cnt;

  coulomb_glass_metropolis_step i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cgm_exchange_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .n_results  (n_results),
    .n_accepted (n_accepted),
    .n_saturated(n_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if (steady) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  // moderate site energy, within about +-3.0
  function automatic logic [31:0] mild_energy();
    return 32'($signed($urandom_range(0, 393216)) - 196608);
  endfunction

  // result side back-pressure
  initial begin
    out_tready = 1'b0;
    hold_cnt   = 0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        hold_cnt = gap_len();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // drive one command beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_cmd(input cmd_t cmd, input logic [3:0] ex, input logic [3:0] ey,
                          input logic [3:0] hx, input logic [3:0] hy,
                          input logic [15:0] draw, input logic occ,
                          input logic [31:0] en);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, en, occ, draw, hy, hx, ey, ex};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic load_site(input logic [3:0] x, input logic [3:0] y, input logic [31:0] en);
    send_cmd(CMD_LOAD, x, y, 4'd0, 4'd0, 16'($urandom), 1'($urandom), en);
  endtask

  task automatic propose(input logic [3:0] ex, input logic [3:0] ey,
                         input logic [3:0] hx, input logic [3:0] hy, input logic [15:0] draw);
    send_cmd(CMD_PROPOSE, ex, ey, hx, hy, draw, 1'($urandom), 32'($urandom));
  endtask

  task automatic read_site(input logic [3:0] x, input logic [3:0] y);
    send_cmd(CMD_READ, x, y, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom),
             32'($urandom));
  endtask

  // lower valid, drain all results, then let the engine settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [23:0] b;
    logic [31:0] st;
    int          pick;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    rst_n     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // fill every site so later sweeps never touch unwritten entries
    for (int s = 0; s < 256; s++) load_site(4'(s / 16), 4'(s % 16), mild_energy());

    // corner cases
    read_site(4'd0, 4'd0);
    read_site(4'd15, 4'd15);
    propose(4'd3, 4'd3, 4'd3, 4'd3, 16'd0);
    propose(4'd0, 4'd0, 4'd15, 4'd15, 16'd0);
    propose(4'd15, 4'd0, 4'd0, 4'd15, 16'hFFFF);
    propose(4'd8, 4'd8, 4'd0, 4'd0, 16'hFFFF);
    propose(4'd5, 4'd6, 4'd5, 4'd7, 16'd1);
    send_cmd(CMD_RESTART, 4'd1, 4'd2, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0);
    load_site(4'd2, 4'd2, 32'h7FFFFFFF);
    load_site(4'd2, 4'd3, 32'h80000000);
    propose(4'd2, 4'd3, 4'd2, 4'd2, 16'd0);
    propose(4'd2, 4'd2, 4'd2, 4'd3, 16'd0);
    propose(4'd9, 4'd9, 4'd2, 4'd3, 16'hFFFF);
    read_site(4'd2, 4'd2);
    read_site(4'd2, 4'd3);
    load_site(4'd2, 4'd2, mild_energy());
    load_site(4'd2, 4'd3, mild_energy());
    read_site(4'd2, 4'd3);
    drain();

    // random traffic over several settings, extremes first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin b = 24'd0;        st = 32'h7FFFFFFF; end
        1: begin b = 24'hFFFFFF;   st = 32'h80000000; end
        2: begin b = 24'd65536;    st = 32'd0;        end
        3: begin b = 24'd0;        st = 32'h80000000; end
        default: begin
          b  = 24'($urandom_range(0, 4 << 16));
          st = 32'($urandom);
        end
      endcase
      write_reg(CFG_BETA, {8'd0, b});
      write_reg(CFG_START, st);
      steady = (ph % 3 == 2);
      send_cmd(CMD_RESTART, 4'($urandom), 4'($urandom), 4'd0, 4'd0, 16'd0, 1'b0, 32'd0);
      for (int n = 0; n < 28; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          if ($urandom_range(0, 19) == 0) begin
            b[3:0] = 4'($urandom);
            b[7:4] = 4'($urandom);
            propose(b[3:0], b[7:4], b[3:0], b[7:4], 16'($urandom));
          end else begin
            propose(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom), 16'($urandom));
          end
        end else if (pick < 78) begin
          read_site(4'($urandom), 4'($urandom));
        end else if (pick < 96) begin
          load_site(4'($urandom), 4'($urandom),
                    ($urandom_range(0, 24) == 0) ? 32'($urandom) : mild_energy());
        end else begin
          send_cmd(CMD_RESTART, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                   16'($urandom), 1'($urandom), 32'($urandom));
        end
      end
      drain();
    end
    steady = 1'b0;
    repeat (300) @(posedge clk);

    $display("Checked %0d results: %0d exchanges accepted, %0d with clipping,",
             n_results, n_accepted, n_saturated);
    $display("across six temperature and start-energy settings with random stalls.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("Timeout waiting for the engine");
    $display("Test completed with failures");
    $finish;
  end

endmodule
